@@ hw/rtl/prlb_pkg.sv @@
// Shared constants and codes for the persistent ring log buffer.
package prlb_pkg;

   localparam int RING_DEPTH_DEFAULT = 4096;

   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;
   localparam int POS_W = 12;
   localparam int MLEN_W = 16;
   localparam int SIZE_W = 13;
   localparam int STATUS_W = 2;
   localparam int WRONG_W = 6;
   localparam int SIZE_MAX = (1 << SIZE_W) - 1;

   localparam logic [SIZE_W-1:0] BUFFER_SIZE_RESET = 13'd4096;
   localparam logic [31:0] MAGIC_CONST = 32'h676f6c6b;
   localparam logic [WRONG_W-1:0] WRONG_LIMIT = 6'd3;

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SALVAGE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_END = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

endpackage

@@ hw/rtl/persistent_ring_log_buffer.sv @@
// Top level of the persistent ring log buffer: header registers, ring memory and result stage.
//
// A request is taken on every clock edge at which start is high and busy is low, and its
// result appears on the rsp_ ports, marked by rsp_strobe, in the next cycle; the
// receiver cannot stall, so each result must be captured in that cycle. Busy is low except
// after a write of buffer_size: the block then reduces the stored write offset modulo the
// new size with a one-bit-per-cycle remainder unit and holds busy high until it ends. The
// ring contents are not cleared at reset; reads end at the write offset, or the size once wrapped.
module persistent_ring_log_buffer #(
   parameter int RING_DEPTH = prlb_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [prlb_pkg::MODE_W-1:0]   req_mode,
   input  logic [prlb_pkg::BYTE_W-1:0]   req_data_byte,
   input  logic [prlb_pkg::POS_W-1:0]    req_position,
   input  logic [prlb_pkg::MLEN_W-1:0]   req_message_length,
   output logic                          rsp_strobe,
   output logic [prlb_pkg::BYTE_W-1:0]   rsp_data_out,
   output logic [prlb_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_header_kept,
   output logic [prlb_pkg::WRONG_W-1:0]  rsp_wrong_bits,
   output logic                          rsp_wrapped,
   output logic [prlb_pkg::POS_W-1:0]    rsp_fill_offset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [prlb_pkg::SIZE_W-1:0]   csr_buffer_size
);

   localparam int SW = prlb_pkg::SIZE_W;
   localparam int AW = $clog2(RING_DEPTH);
   localparam int SizeCap = (RING_DEPTH > prlb_pkg::SIZE_MAX) ? prlb_pkg::SIZE_MAX : RING_DEPTH;
   localparam int CW = $clog2(SW);

   logic [7:0] ring_mem [RING_DEPTH];

   logic [SW-1:0] buffer_size_ff;
   logic [SW-1:0] write_offset_ff, write_offset_in;
   logic [SW-1:0] off_mod_ff, off_mod_in;
   logic          wrapped_ff, wrapped_in;
   logic [31:0]   magic_ff, magic_in;

   logic          mod_run_ff;
   logic [CW-1:0] mod_cnt_ff;
   logic [SW-1:0] mod_rem_ff;
   logic [SW:0]   mod_trial;
   logic [SW-1:0] mod_rem_in;

   logic                          rsp_strobe_ff;
   logic [prlb_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          kept_ff, kept_in;
   logic [prlb_pkg::WRONG_W-1:0]  wrong_ff, wrong_in;
   logic                          read_ok_ff, read_ok_in;
   logic [7:0]                    mem_rd_ff;

   logic          accept;
   logic [SW-1:0] size;
   logic [SW:0]   off_next;
   logic [SW-1:0] total;
   logic [SW-1:0] oldest;
   logic [SW:0]   sum;
   logic [SW-1:0] idx;
   logic [prlb_pkg::WRONG_W-1:0] wrong_cnt;
   logic          mem_wr;
   logic          mem_rd;

   assign accept = start && !busy;
   assign busy = mod_run_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      if (buffer_size_ff == '0) begin
         size = SW'(1);
      end else if (buffer_size_ff > SW'(SizeCap)) begin
         size = SW'(SizeCap);
      end else begin
         size = buffer_size_ff;
      end
   end

   assign off_next = {1'b0, off_mod_ff} + (SW+1)'(1);
   assign total = wrapped_ff ? size : write_offset_ff;
   assign oldest = wrapped_ff ? off_mod_ff : '0;
   assign sum = {1'b0, oldest} + (SW+1)'(req_position);
   assign idx = (sum >= {1'b0, total}) ? SW'(sum - {1'b0, total}) : sum[SW-1:0];
   assign wrong_cnt = prlb_pkg::WRONG_W'($countones(magic_ff ^ prlb_pkg::MAGIC_CONST));

   always_comb begin
      write_offset_in = write_offset_ff;
      off_mod_in = off_mod_ff;
      wrapped_in = wrapped_ff;
      magic_in = magic_ff;
      status_in = prlb_pkg::STATUS_OK;
      kept_in = 1'b0;
      wrong_in = '0;
      read_ok_in = 1'b0;
      mem_wr = 1'b0;
      mem_rd = 1'b0;
      unique case (req_mode)
         prlb_pkg::MODE_APPEND: begin
            if (req_message_length > prlb_pkg::MLEN_W'(size)) begin
               status_in = prlb_pkg::STATUS_TOO_LONG;
            end else begin
               mem_wr = 1'b1;
               if (off_next >= {1'b0, size}) begin
                  write_offset_in = '0;
                  off_mod_in = '0;
                  wrapped_in = 1'b1;
               end else begin
                  write_offset_in = off_next[SW-1:0];
                  off_mod_in = off_next[SW-1:0];
               end
            end
         end
         prlb_pkg::MODE_READ: begin
            if (SW'(req_position) >= total) begin
               status_in = prlb_pkg::STATUS_END;
            end else begin
               read_ok_in = 1'b1;
               mem_rd = 1'b1;
            end
         end
         prlb_pkg::MODE_SALVAGE: begin
            wrong_in = wrong_cnt;
            if (wrong_cnt < prlb_pkg::WRONG_LIMIT && write_offset_ff < size) begin
               kept_in = 1'b1;
            end else begin
               write_offset_in = '0;
               off_mod_in = '0;
               wrapped_in = 1'b0;
            end
            if (wrong_cnt != '0) begin
               magic_in = prlb_pkg::MAGIC_CONST;
            end
         end
         prlb_pkg::MODE_UNUSED: begin
         end
         default: begin
         end
      endcase
   end

   // Restoring remainder step: one dividend bit of the write offset per cycle.
   assign mod_trial = {mod_rem_ff, write_offset_ff[mod_cnt_ff]};
   assign mod_rem_in = (mod_trial >= {1'b0, size}) ? SW'(mod_trial - {1'b0, size})
                                                   : mod_trial[SW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= prlb_pkg::BUFFER_SIZE_RESET;
         write_offset_ff <= '0;
         off_mod_ff <= '0;
         wrapped_ff <= 1'b0;
         magic_ff <= '0;
         mod_run_ff <= 1'b0;
         mod_cnt_ff <= '0;
         mod_rem_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= accept;
         if (accept) begin
            write_offset_ff <= write_offset_in;
            off_mod_ff <= off_mod_in;
            wrapped_ff <= wrapped_in;
            magic_ff <= magic_in;
         end
         if (csr_valid && csr_ready) begin
            buffer_size_ff <= csr_buffer_size;
            mod_run_ff <= 1'b1;
            mod_cnt_ff <= CW'(SW - 1);
            mod_rem_ff <= '0;
         end else if (mod_run_ff) begin
            mod_rem_ff <= mod_rem_in;
            mod_cnt_ff <= mod_cnt_ff - CW'(1);
            if (mod_cnt_ff == '0) begin
               mod_run_ff <= 1'b0;
               off_mod_ff <= mod_rem_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         kept_ff <= kept_in;
         wrong_ff <= wrong_in;
         read_ok_ff <= read_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mem_wr) begin
         ring_mem[AW'(off_mod_ff)] <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mem_rd) begin
         mem_rd_ff <= ring_mem[AW'(idx)];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data_out = read_ok_ff ? mem_rd_ff : '0;
   assign rsp_status = status_ff;
   assign rsp_header_kept = kept_ff;
   assign rsp_wrong_bits = wrong_ff;
   assign rsp_wrapped = wrapped_ff;
   assign rsp_fill_offset = write_offset_ff[prlb_pkg::POS_W-1:0];

endmodule

@@ hw/rtl/prlb_checker.sv @@
// Port-level assertions for the persistent ring log buffer and their bind.
module prlb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [prlb_pkg::BYTE_W-1:0]   rsp_data_out,
   input logic [prlb_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_header_kept,
   input logic [prlb_pkg::WRONG_W-1:0]  rsp_wrong_bits,
   input logic                          csr_valid,
   input logic                          csr_ready
);

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("Accepted request produced no result.");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!(start && !busy)) |=> !rsp_strobe)
      else $error("Result without a request.");

   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == prlb_pkg::STATUS_END) |-> rsp_data_out == '0)
      else $error("End of data carries a nonzero byte.");

   a_kept_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_header_kept) |-> rsp_wrong_bits < prlb_pkg::WRONG_LIMIT)
      else $error("Header kept with too many wrong magic bits.");

   a_size_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("Size write did not start offset reduction.");

endmodule

bind persistent_ring_log_buffer prlb_checker u_prlb_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_strobe(rsp_strobe),
   .rsp_data_out(rsp_data_out),
   .rsp_status(rsp_status),
   .rsp_header_kept(rsp_header_kept),
   .rsp_wrong_bits(rsp_wrong_bits),
   .csr_valid(csr_valid),
   .csr_ready(csr_ready)
);
